FILE: rtl/hs_pkg.sv
// ----------------------------------------------------------------------------
// hs_pkg
// Shared types and constants of the heap sorter: datapath operations, the
// status word sent back to the controller, port widths and register indexes.
// ----------------------------------------------------------------------------
package hs_pkg;

   localparam int KEY_PORT_W = 32;
   localparam int POS_W      = 6;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SORT_ORDER  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_KEYS_SIGNED = CSR_IDX_W'(1);

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_BLD_INIT,
      OP_BLD_STEP,
      OP_PAR_LD,
      OP_EXT_INIT,
      OP_RD_ROOT,
      OP_RD_LAST,
      OP_EXT_STEP,
      OP_SIFT_L,
      OP_SIFT_R,
      OP_SIFT_LSWAP,
      OP_SIFT_SEL,
      OP_SIFT_SWAP,
      OP_SIFT_FIN,
      OP_EMIT_INIT,
      OP_EMIT,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic k_zero;
      logic k_le_one;
      logic l_out;
      logic r_in;
      logic left_prec;
      logic child_prec;
      logic emit_last;
   } sts_type;

endpackage

FILE: rtl/hs_ram.sv
// ----------------------------------------------------------------------------
// hs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/hs_ctrl.sv
// ----------------------------------------------------------------------------
// hs_ctrl
// Sequencer of the heap sorter: load, heap build, root extraction with
// sift-down, and emission of the sorted store.
// ----------------------------------------------------------------------------
module hs_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            last,
   input  hs_pkg::sts_type sts,
   output hs_pkg::op_type  op,
   output logic            busy
);
   import hs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B_INIT,
      ST_B_LOOP,
      ST_B_PAR,
      ST_X_LOOP,
      ST_X_ROOT,
      ST_X_LAST,
      ST_S_L,
      ST_S_R,
      ST_S_CMP,
      ST_S_SWP,
      ST_S_FIN,
      ST_EMIT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;   // 0: heap build, 1: extraction
   state_type ret_st;

   assign ret_st = phase_ff ? ST_X_LOOP : ST_B_LOOP;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      op       = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op = OP_LOAD;
               if (last) begin
                  state_in = ST_B_INIT;
               end
            end
         end
         ST_B_INIT: begin
            op       = OP_BLD_INIT;
            phase_in = 1'b0;
            state_in = ST_B_LOOP;
         end
         ST_B_LOOP: begin
            if (sts.k_zero) begin
               op       = OP_EXT_INIT;
               phase_in = 1'b1;
               state_in = ST_X_LOOP;
            end else begin
               op       = OP_BLD_STEP;
               state_in = ST_B_PAR;
            end
         end
         ST_B_PAR: begin
            op       = OP_PAR_LD;
            state_in = ST_S_L;
         end
         ST_X_LOOP: begin
            if (sts.k_le_one) begin
               op       = OP_EMIT_INIT;
               state_in = ST_EMIT;
            end else begin
               op       = OP_RD_ROOT;
               state_in = ST_X_ROOT;
            end
         end
         ST_X_ROOT: begin
            op       = OP_RD_LAST;
            state_in = ST_X_LAST;
         end
         ST_X_LAST: begin
            op       = OP_EXT_STEP;
            state_in = ST_S_L;
         end
         ST_S_L: begin
            if (sts.l_out) begin
               op       = OP_SIFT_FIN;
               state_in = ret_st;
            end else begin
               op       = OP_SIFT_L;
               state_in = ST_S_R;
            end
         end
         ST_S_R: begin
            if (sts.r_in) begin
               op       = OP_SIFT_R;
               state_in = ST_S_CMP;
            end else if (sts.left_prec) begin
               // only a left child, and it moves up
               op       = OP_SIFT_LSWAP;
               state_in = ST_S_FIN;
            end else begin
               state_in = ST_S_FIN;
            end
         end
         ST_S_CMP: begin
            op       = OP_SIFT_SEL;
            state_in = ST_S_SWP;
         end
         ST_S_SWP: begin
            if (sts.child_prec) begin
               op       = OP_SIFT_SWAP;
               state_in = ST_S_L;
            end else begin
               op       = OP_SIFT_FIN;
               state_in = ret_st;
            end
         end
         ST_S_FIN: begin
            op       = OP_SIFT_FIN;
            state_in = ret_st;
         end
         ST_EMIT: begin
            op = OP_EMIT;
            if (sts.emit_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            op       = OP_CLEAR;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/hs_dp.sv
// ----------------------------------------------------------------------------
// hs_dp
// Datapath of the heap sorter: key store, heap indexes, held sift key,
// comparators, configuration registers and the result register.
// ----------------------------------------------------------------------------
module hs_dp #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hs_pkg::op_type                op,
   output hs_pkg::sts_type               sts,
   input  logic [hs_pkg::KEY_PORT_W-1:0] key,
   input  logic                          csr_wr,
   input  logic [hs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [hs_pkg::KEY_PORT_W-1:0] sorted_key,
   output logic [hs_pkg::POS_W-1:0]      position,
   output logic                          overflow,
   output logic                          end_of_set,
   output logic                          valid
);
   import hs_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = AW + 2;

   function automatic logic prec(input logic [KEY_WIDTH-1:0] a,
                                 input logic [KEY_WIDTH-1:0] b,
                                 input logic                 desc,
                                 input logic                 sgn);
      logic [KEY_WIDTH-1:0] x;
      logic [KEY_WIDTH-1:0] y;
      x = a;
      y = b;
      // flip sign bits so an unsigned compare orders two's complement keys
      x[KEY_WIDTH-1] = a[KEY_WIDTH-1] ^ sgn;
      y[KEY_WIDTH-1] = b[KEY_WIDTH-1] ^ sgn;
      return desc ? (x > y) : (x < y);
   endfunction

   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [AW-1:0]        node_ff, node_in;
   logic [CW-1:0]        size_ff, size_in;
   logic [KEY_WIDTH-1:0] par_ff, par_in;
   logic [KEY_WIDTH-1:0] left_ff, left_in;
   logic [KEY_WIDTH-1:0] child_ff, child_in;
   logic [AW-1:0]        cidx_ff, cidx_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 eos_ff, eos_in;
   logic                 outv_ff, outv_in;
   logic                 order_ff, order_in;
   logic                 sgn_ff, sgn_in;

   logic                 we;
   logic [AW-1:0]        waddr;
   logic [KEY_WIDTH-1:0] wdata;
   logic [AW-1:0]        raddr;
   logic [KEY_WIDTH-1:0] rdata;

   logic [KEY_WIDTH-1:0] key_trim;
   logic [CW-1:0]        km1;
   logic [LW-1:0]        l_idx;
   logic [LW-1:0]        r_idx;
   logic [LW-1:0]        size_x;
   logic                 sel_left;

   hs_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   assign key_trim = KEY_WIDTH'(key);
   assign km1      = k_ff - CW'(1);
   assign l_idx    = LW'({node_ff, 1'b1});
   assign r_idx    = LW'({node_ff, 1'b0}) + LW'(2);
   assign size_x   = LW'(size_ff);
   assign sel_left = prec(left_ff, rdata, order_ff, sgn_ff);

   assign sts.k_zero     = (k_ff == '0);
   assign sts.k_le_one   = (k_ff <= CW'(1));
   assign sts.l_out      = (l_idx >= size_x);
   assign sts.r_in       = (r_idx < size_x);
   assign sts.left_prec  = prec(rdata, par_ff, order_ff, sgn_ff);
   assign sts.child_prec = prec(child_ff, par_ff, order_ff, sgn_ff);
   assign sts.emit_last  = (k_ff == cnt_ff - CW'(1));

   always_comb begin
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      k_in     = k_ff;
      node_in  = node_ff;
      size_in  = size_ff;
      par_in   = par_ff;
      left_in  = left_ff;
      child_in = child_ff;
      cidx_in  = cidx_ff;
      pos_in   = pos_ff;
      eos_in   = eos_ff;
      outv_in  = 1'b0;
      order_in = order_ff;
      sgn_in   = sgn_ff;
      we       = 1'b0;
      waddr    = node_ff;
      wdata    = par_ff;
      raddr    = '0;

      case (op)
         OP_LOAD: begin
            if (cnt_ff < CW'(DEPTH)) begin
               we     = 1'b1;
               waddr  = cnt_ff[AW-1:0];
               wdata  = key_trim;
               cnt_in = cnt_ff + CW'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         OP_BLD_INIT: begin
            k_in = cnt_ff >> 1;
         end
         OP_BLD_STEP: begin
            node_in = km1[AW-1:0];
            size_in = cnt_ff;
            k_in    = km1;
            raddr   = km1[AW-1:0];
         end
         OP_PAR_LD: begin
            par_in = rdata;
         end
         OP_EXT_INIT: begin
            k_in = cnt_ff;
         end
         OP_RD_ROOT: begin
            raddr = '0;
         end
         OP_RD_LAST: begin
            left_in = rdata;
            raddr   = km1[AW-1:0];
         end
         OP_EXT_STEP: begin
            // old root goes to the end, old end becomes the sift key
            par_in  = rdata;
            we      = 1'b1;
            waddr   = km1[AW-1:0];
            wdata   = left_ff;
            node_in = '0;
            size_in = km1;
            k_in    = km1;
         end
         OP_SIFT_L: begin
            raddr = l_idx[AW-1:0];
         end
         OP_SIFT_R: begin
            left_in = rdata;
            raddr   = r_idx[AW-1:0];
         end
         OP_SIFT_LSWAP: begin
            we      = 1'b1;
            wdata   = rdata;
            node_in = l_idx[AW-1:0];
         end
         OP_SIFT_SEL: begin
            // ties pick the right child
            if (sel_left) begin
               child_in = left_ff;
               cidx_in  = l_idx[AW-1:0];
            end else begin
               child_in = rdata;
               cidx_in  = r_idx[AW-1:0];
            end
         end
         OP_SIFT_SWAP: begin
            we      = 1'b1;
            wdata   = child_ff;
            node_in = cidx_ff;
         end
         OP_SIFT_FIN: begin
            // the held key lands in its final slot
            we = 1'b1;
         end
         OP_EMIT_INIT: begin
            k_in = '0;
         end
         OP_EMIT: begin
            raddr   = k_ff[AW-1:0];
            pos_in  = POS_W'(k_ff[AW-1:0]);
            eos_in  = sts.emit_last;
            outv_in = 1'b1;
            k_in    = k_ff + CW'(1);
         end
         OP_CLEAR: begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end
         default: begin
         end
      endcase

      if (csr_wr) begin
         case (csr_index)
            CSR_SORT_ORDER:  order_in = csr_wdata[0];
            CSR_KEYS_SIGNED: sgn_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         k_ff     <= '0;
         node_ff  <= '0;
         size_ff  <= '0;
         outv_ff  <= 1'b0;
         order_ff <= 1'b0;
         sgn_ff   <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         k_ff     <= k_in;
         node_ff  <= node_in;
         size_ff  <= size_in;
         outv_ff  <= outv_in;
         order_ff <= order_in;
         sgn_ff   <= sgn_in;
      end
   end

   always_ff @(posedge clock) begin
      par_ff   <= par_in;
      left_ff  <= left_in;
      child_ff <= child_in;
      cidx_ff  <= cidx_in;
      pos_ff   <= pos_in;
      eos_ff   <= eos_in;
   end

   assign sorted_key = KEY_PORT_W'(rdata);
   assign position   = pos_ff;
   assign overflow   = ovf_ff;
   assign end_of_set = eos_ff;
   assign valid      = outv_ff;

endmodule

FILE: rtl/heap_sorter.sv
// Loading: one cycle per key; start is taken whenever busy is low.
// After the closing key: the heap build sifts down each inner node and the
// extraction sifts down the new root after each extracted root, level by
// level, bounded by the single read port of the key store.
// Emission: one sorted key per cycle, then busy drops once the set is cleared.
// Reset (synchronous, active high) empties the set and clears both registers.
// ----------------------------------------------------------------------------
// heap_sorter
// Loads keys into a store until the closing key, heap-sorts them in place
// and streams the sorted store out; keys beyond the store depth are dropped
// and flagged.
// ----------------------------------------------------------------------------
module heap_sorter #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hs_pkg::KEY_PORT_W-1:0] req_key,
   input  logic                          req_last,
   output logic                          rsp_valid,
   output logic [hs_pkg::KEY_PORT_W-1:0] rsp_sorted_key,
   output logic [hs_pkg::POS_W-1:0]      rsp_position,
   output logic                          rsp_overflow,
   output logic                          rsp_end_of_set,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hs_pkg::*;

   op_type  op;
   sts_type sts;

   assign csr_ready = 1'b1;

   hs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .last  (req_last),
      .sts   (sts),
      .op    (op),
      .busy  (busy)
   );

   hs_dp #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .sts        (sts),
      .key        (req_key),
      .csr_wr     (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sorted_key (rsp_sorted_key),
      .position   (rsp_position),
      .overflow   (rsp_overflow),
      .end_of_set (rsp_end_of_set),
      .valid      (rsp_valid)
   );

`ifndef SYNTHESIS
   a_beat_while_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   a_no_beat_after_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_set |=> !rsp_valid)
      else $error("result beat after end of set");

   a_position_steps : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_set |=>
         rsp_valid && (rsp_position == $past(rsp_position) + 1'b1))
      else $error("result positions not consecutive");
`endif

endmodule

FILE: sim/heap_sorter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap_sorter_tb
// Loads sets of keys into the heap sorter and checks every sorted beat against
// a behavioral heapsort kept in the bench. The sets include single keys,
// extremes, ties, full and overflowing stores, and run under all four settings
// of order and signedness, with random gaps between input beats.
// ----------------------------------------------------------------------------
module heap_sorter_tb;
   import hs_pkg::*;

   localparam int STORE_DEPTH   = 64;
   localparam int ITEM_TARGET   = 470;
   localparam int SETTLE_CYCLES = 20;
   localparam int IDLE_LIMIT    = 20000;
   localparam int PRINT_CAP     = 40;

   typedef struct {
      logic [KEY_PORT_W-1:0] key;
      logic                  last;
   } key_beat_type;

   typedef struct {
      logic [KEY_PORT_W-1:0] key;
      logic [POS_W-1:0]      pos;
      logic                  ovf;
      logic                  eos;
   } sorted_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [KEY_PORT_W-1:0] req_key = '0;
   logic                  req_last = 1'b0;
   logic                  rsp_valid;
   logic [KEY_PORT_W-1:0] rsp_sorted_key;
   logic [POS_W-1:0]      rsp_position;
   logic                  rsp_overflow;
   logic                  rsp_end_of_set;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   heap_sorter #(
      .DEPTH     (STORE_DEPTH),
      .KEY_WIDTH (KEY_PORT_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_key        (req_key),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_sorted_key (rsp_sorted_key),
      .rsp_position   (rsp_position),
      .rsp_overflow   (rsp_overflow),
      .rsp_end_of_set (rsp_end_of_set),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // bench copy of the sorter state
   // ---------------------------------------------------------------------
   logic [KEY_PORT_W-1:0] heap_keys [STORE_DEPTH];
   int unsigned           keys_held = 0;
   bit                    keys_dropped = 1'b0;
   bit                    order_desc_cmp = 1'b0;   // 1: greater-than comparator
   bit                    cmp_signed = 1'b0;

   key_beat_type    pending_keys[$];
   sorted_beat_type sorted_expect[$];
   int unsigned     keys_unsent = 0;
   int unsigned     keys_made = 0;
   int unsigned     errors = 0;
   bit              no_idle = 1'b0;

   task automatic report_mismatch(input string what);
      if (errors < PRINT_CAP)
         $display("%0t mismatch: %s", $realtime, what);
      errors++;
   endtask

   // true when a must sit above b in the heap
   function automatic bit sits_above(logic [KEY_PORT_W-1:0] a, logic [KEY_PORT_W-1:0] b);
      logic [KEY_PORT_W-1:0] x;
      logic [KEY_PORT_W-1:0] y;
      x = a;
      y = b;
      if (cmp_signed) begin
         x[KEY_PORT_W-1] = ~x[KEY_PORT_W-1];
         y[KEY_PORT_W-1] = ~y[KEY_PORT_W-1];
      end
      return order_desc_cmp ? (x > y) : (x < y);
   endfunction

   function automatic void swap_keys(int unsigned i, int unsigned j);
      logic [KEY_PORT_W-1:0] t;
      t = heap_keys[i];
      heap_keys[i] = heap_keys[j];
      heap_keys[j] = t;
   endfunction

   function automatic void sift_down(int unsigned node, int unsigned size);
      int unsigned lc;
      int unsigned rc;
      int unsigned pick;
      bit          done;
      done = 1'b0;
      while (!done) begin
         lc = 2 * node + 1;
         rc = 2 * node + 2;
         if (rc < size) begin
            // ties go to the right child
            pick = sits_above(heap_keys[lc], heap_keys[rc]) ? lc : rc;
            if (!sits_above(heap_keys[pick], heap_keys[node])) begin
               done = 1'b1;
            end else begin
               swap_keys(pick, node);
               node = pick;
            end
         end else begin
            if (lc < size && sits_above(heap_keys[lc], heap_keys[node]))
               swap_keys(lc, node);
            done = 1'b1;
         end
      end
   endfunction

   function automatic void heap_sort(int unsigned n);
      int unsigned i;
      for (i = n / 2; i > 0; i--)
         sift_down(i - 1, n);
      for (i = n; i > 1; i--) begin
         swap_keys(0, i - 1);
         sift_down(0, i - 1);
      end
   endfunction

   // one accepted input beat: store the key, and on the closing beat sort
   function automatic void load_key(logic [KEY_PORT_W-1:0] key, logic last);
      sorted_beat_type s;
      int unsigned     i;
      if (keys_held < STORE_DEPTH) begin
         heap_keys[keys_held] = key;
         keys_held++;
      end else begin
         keys_dropped = 1'b1;
      end
      if (last) begin
         heap_sort(keys_held);
         for (i = 0; i < keys_held; i++) begin
            s.key = heap_keys[i];
            s.pos = POS_W'(i);
            s.ovf = keys_dropped;
            s.eos = (i + 1 == keys_held);
            sorted_expect.push_back(s);
         end
         keys_held = 0;
         keys_dropped = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // driver
   // ---------------------------------------------------------------------
   bit           holding = 1'b0;
   int           gap_left = 0;
   key_beat_type cur_beat;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         holding = 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            load_key(req_key, req_last);
            keys_unsent--;
            holding = 1'b0;
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_keys.size() > 0) begin
               cur_beat = pending_keys.pop_front();
               req_key <= cur_beat.key;
               req_last <= cur_beat.last;
               holding = 1'b1;
               gap_left = no_idle ? 0 : $urandom_range(0, 7);
            end
         end
         start <= holding;
      end
   end

   // ---------------------------------------------------------------------
   // monitor
   // ---------------------------------------------------------------------
   sorted_beat_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (sorted_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected beat key %h pos %0d",
                                      rsp_sorted_key, rsp_position));
         end else begin
            want = sorted_expect.pop_front();
            if (rsp_sorted_key !== want.key)
               report_mismatch($sformatf("pos %0d key %h, want %h",
                                         want.pos, rsp_sorted_key, want.key));
            if (rsp_position !== want.pos)
               report_mismatch($sformatf("position %0d, want %0d",
                                         rsp_position, want.pos));
            if (rsp_overflow !== want.ovf)
               report_mismatch($sformatf("pos %0d overflow %b, want %b",
                                         want.pos, rsp_overflow, want.ovf));
            if (rsp_end_of_set !== want.eos)
               report_mismatch($sformatf("pos %0d end_of_set %b, want %b",
                                         want.pos, rsp_end_of_set, want.eos));
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: cycles with no beat on any channel
   // ---------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   // leaves csr_valid high; the caller drops it after its last write
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SORT_ORDER)
         order_desc_cmp = data[0];
      else if (idx == CSR_KEYS_SIGNED)
         cmp_signed = data[0];
   endtask

   task automatic set_config(input bit desc, input bit signed_keys);
      csr_write(CSR_SORT_ORDER, {(CSR_DATA_W-1)'($urandom), desc});
      csr_write(CSR_KEYS_SIGNED, {(CSR_DATA_W-1)'($urandom), signed_keys});
      // indexes past the register map are ignored
      csr_write(CSR_IDX_W'($urandom_range(2, 255)), CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_key(input logic [KEY_PORT_W-1:0] key, input logic last);
      key_beat_type b;
      b.key = key;
      b.last = last;
      pending_keys.push_back(b);
      keys_unsent++;
      keys_made++;
   endtask

   function automatic logic [KEY_PORT_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1:    return KEY_PORT_W'($urandom_range(0, 3));   // dense values force ties
         2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         default: return KEY_PORT_W'($urandom);
      endcase
   endfunction

   task automatic queue_set(input int unsigned n);
      int unsigned i;
      for (i = 0; i < n; i++)
         queue_key(pick_key(), i == n - 1);
   endtask

   function automatic int unsigned pick_set_size();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return $urandom_range(1, 8);
      else if (roll < 90)
         return $urandom_range(9, 32);
      else if (roll < 97)
         return $urandom_range(33, STORE_DEPTH);
      else
         return $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
   endfunction

   task automatic drain_phase();
      while (keys_unsent != 0 || sorted_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [KEY_PORT_W-1:0] corner_keys [8];
      int unsigned           phase_no;
      int unsigned           s;

      corner_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single key, extremes with ties, equal pair
      set_config(1'b0, 1'b0);
      queue_key(32'hFFFF_FFFF, 1'b1);
      for (s = 0; s < 8; s++)
         queue_key(corner_keys[s], s == 7);
      drain_phase();

      set_config(1'b1, 1'b1);
      for (s = 0; s < 8; s++)
         queue_key(corner_keys[s], s == 7);
      queue_key(32'h8000_0000, 1'b0);
      queue_key(32'h8000_0000, 1'b1);
      drain_phase();

      // random sets; the first phase forces a full store and two overflows
      phase_no = 0;
      while (keys_made < ITEM_TARGET) begin
         set_config(phase_no[0], phase_no[1]);
         no_idle = ($urandom_range(0, 3) == 0);
         if (phase_no == 0) begin
            queue_set(STORE_DEPTH);
            queue_set(STORE_DEPTH + 1);
            queue_set(STORE_DEPTH + 6);
         end
         for (s = 0; s < 5; s++)
            queue_set(pick_set_size());
         drain_phase();
         phase_no++;
      end

      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: heap_sorter.f
rtl/hs_pkg.sv
rtl/hs_ram.sv
rtl/hs_ctrl.sv
rtl/hs_dp.sv
rtl/heap_sorter.sv
sim/heap_sorter_tb.sv
